/* rtl/core/tblit_pkg.sv */
// tblit_pkg: shared types and codes for the 4bpp tile blitter.
// No dependencies; imported by every module of the block except tblit_fifo.
`default_nettype none

package tblit_pkg;

  // configuration register
  localparam int CFG_W = 11;
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET = 11'd320;
  localparam logic REG_FRAME_WIDTH = 1'b0;  // paddr[2] of the frame_width register

  // input item codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  // nibble enables of one write beat
  localparam logic [1:0] MASK_LO = 2'b01;
  localparam logic [1:0] MASK_HI = 2'b10;

  localparam logic [3:0] NIB_ZERO = 4'h0;

  // one classified tile byte on its way from the front to the back
  typedef struct packed {
    logic [3:0] lo;     // even tile column
    logic [3:0] hi;     // odd tile column
    logic       lo_w;   // low pixel is written
    logic       hi_w;   // high pixel is written
    logic       odd;    // tile starts on an odd column: pixels straddle bytes
  } pix_op_t;

endpackage

`default_nettype wire

/* rtl/core/tblit_fifo.sv */
// tblit_fifo: small register queue between the front and the back.
// Uses no package; width and depth come from parameters.
`default_nettype none

module tblit_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CW'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tblit_front.sv */
// tblit_front: takes start and data beats, tracks tile position, classifies bytes.
// Depends on tblit_pkg.
`default_nettype none

module tblit_front #(
  parameter int MAX_FRAME_WIDTH = 1024,
  parameter int MAX_TILE_SIDE   = 32,
  parameter int ADDR_BITS       = 19
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [tblit_pkg::CFG_W-1:0] frame_width,
  input  wire logic                      accept,
  input  wire logic                      cmd,
  input  wire logic [9:0]                tile_x,
  input  wire logic [9:0]                tile_y,
  input  wire logic [5:0]                tile_side,
  input  wire logic                      transparent,
  input  wire logic [7:0]                tile_byte,
  output logic                           op_push,
  output logic [ADDR_BITS-1:0]           op_addr,
  output tblit_pkg::pix_op_t             op
);
  import tblit_pkg::*;

  localparam int PA   = ADDR_BITS + 1;
  localparam int FW   = $clog2(MAX_FRAME_WIDTH + 1);
  localparam int CFW  = (FW > CFG_W) ? FW : CFG_W;
  localparam int SW   = $clog2(MAX_TILE_SIDE + 1);
  localparam int CSW  = (SW > 6) ? SW : 6;
  localparam int BW   = $clog2((MAX_TILE_SIDE + 1) / 2 + 1);
  localparam int CMPW = ((BW + 1 > SW) ? BW + 1 : SW) + 1;
  localparam int MW   = 10 + FW;

  logic [PA-1:0] row_pixel_addr;
  logic [SW-1:0] row_count;
  logic [BW-1:0] byte_in_row;
  logic [SW-1:0] side_held;
  logic          skip_zero;
  logic          odd_column;
  logic          tile_active;

  logic [CFW-1:0]  fw_even;
  logic [FW-1:0]   eff_w;
  logic [CSW-1:0]  side_ext;
  logic [SW-1:0]   side_sat;
  logic [MW:0]     start_sum;
  logic [CMPW-1:0] col_p1;
  logic [CMPW-1:0] bpr;
  logic            hi_valid;
  logic            byte_last;
  logic            row_last;
  logic [PA-1:0]   pix;
  logic [3:0]      lo;
  logic [3:0]      hi;
  logic            lo_w;
  logic            hi_w;
  logic            data_go;

  // even width, clamped to the largest supported row
  always_comb begin
    fw_even = CFW'(frame_width) & ~CFW'(1);
    if (fw_even > CFW'(MAX_FRAME_WIDTH)) begin
      eff_w = FW'(MAX_FRAME_WIDTH) & ~FW'(1);
    end else begin
      eff_w = FW'(fw_even);
    end
  end

  always_comb begin
    side_ext  = CSW'(tile_side);
    side_sat  = (side_ext > CSW'(MAX_TILE_SIDE)) ? SW'(MAX_TILE_SIDE) : SW'(side_ext);
    start_sum = (MW + 1)'(tile_y) * (MW + 1)'(eff_w) + (MW + 1)'(tile_x);
  end

  always_comb begin
    lo        = tile_byte[3:0];
    hi        = tile_byte[7:4];
    col_p1    = CMPW'({byte_in_row, 1'b0}) + CMPW'(1);
    hi_valid  = col_p1 < CMPW'(side_held);
    lo_w      = !skip_zero || (lo != NIB_ZERO);
    hi_w      = hi_valid && (!skip_zero || (hi != NIB_ZERO));
    pix       = row_pixel_addr + PA'({byte_in_row, 1'b0});
    bpr       = (CMPW'(side_held) + CMPW'(1)) >> 1;
    byte_last = (CMPW'(byte_in_row) + CMPW'(1)) >= bpr;
    row_last  = (CMPW'(row_count) + CMPW'(1)) >= CMPW'(side_held);
    data_go   = accept && (cmd == CMD_DATA) && tile_active;
  end

  assign op_push = data_go && (lo_w || hi_w);
  assign op_addr = pix[PA-1:1];
  assign op      = '{lo: lo, hi: hi, lo_w: lo_w, hi_w: hi_w, odd: odd_column};

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pixel_addr <= '0;
      row_count      <= '0;
      byte_in_row    <= '0;
      side_held      <= '0;
      skip_zero      <= 1'b0;
      odd_column     <= 1'b0;
      tile_active    <= 1'b0;
    end else if (accept && (cmd == CMD_START)) begin
      if (tile_side == 6'd0) begin
        tile_active <= 1'b0;
      end else begin
        side_held      <= side_sat;
        skip_zero      <= transparent;
        odd_column     <= tile_x[0];
        row_pixel_addr <= PA'(start_sum);
        row_count      <= '0;
        byte_in_row    <= '0;
        tile_active    <= 1'b1;
      end
    end else if (data_go) begin
      if (byte_last) begin
        byte_in_row    <= '0;
        row_count      <= row_count + SW'(1);
        row_pixel_addr <= row_pixel_addr + PA'(eff_w);
        if (row_last) begin
          tile_active <= 1'b0;
        end
      end else begin
        byte_in_row <= byte_in_row + BW'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tblit_back.sv */
// tblit_back: expands queued bytes into nibble-masked write beats.
// Depends on tblit_pkg; output register doubles as the result queue head.
`default_nettype none

module tblit_back #(
  parameter int ADDR_BITS = 19
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 op_empty,
  input  wire logic [ADDR_BITS-1:0] op_addr,
  input  wire tblit_pkg::pix_op_t   op,
  output logic                      op_pop,
  output logic                      empty,
  input  wire logic                 pop,
  output logic [ADDR_BITS-1:0]      write_addr,
  output logic [7:0]                write_data,
  output logic [1:0]                nibble_mask,
  output logic                      last_of_run
);
  import tblit_pkg::*;

  logic                 out_valid;
  logic                 phase;      // second beat of a straddling byte
  logic                 load;
  logic                 two_beats;
  logic [ADDR_BITS-1:0] b_addr;
  logic [7:0]           b_data;
  logic [1:0]           b_mask;
  logic                 b_last;

  always_comb begin
    two_beats = op.odd && op.lo_w && op.hi_w;
    load      = !op_empty && (!out_valid || pop);
    op_pop    = load && !(two_beats && !phase);
    if (!op.odd) begin
      b_addr = op_addr;
      b_data = {op.hi_w ? op.hi : NIB_ZERO, op.lo_w ? op.lo : NIB_ZERO};
      b_mask = (op.hi_w ? MASK_HI : 2'b00) | (op.lo_w ? MASK_LO : 2'b00);
      b_last = 1'b1;
    end else if (op.lo_w && !phase) begin
      b_addr = op_addr;
      b_data = {op.lo, NIB_ZERO};
      b_mask = MASK_HI;
      b_last = !op.hi_w;
    end else begin
      b_addr = op_addr + ADDR_BITS'(1);
      b_data = {NIB_ZERO, op.hi};
      b_mask = MASK_LO;
      b_last = 1'b1;
    end
  end

  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        phase     <= two_beats && !phase;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      write_addr  <= b_addr;
      write_data  <= b_data;
      nibble_mask <= b_mask;
      last_of_run <= b_last;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tile_blit_4bpp_transparent_unit.sv */
// tile_blit_4bpp_transparent_unit: top level of the 4bpp tile blitter.
// Depends on tblit_pkg, tblit_front, tblit_fifo and tblit_back.
`default_nettype none

// Places a square tile of 4-bit pixels into a nibble-packed framebuffer
// (even pixel in the low nibble). Push a start beat (cmd 0) with position,
// side and transparency, then one data beat (cmd 1) per tile byte, rows
// padded to an even pixel count. Each data byte gives zero, one or two
// nibble-masked byte writes on the result queue; last_of_run flags the
// final write of a byte. Input beats are taken one per cycle while the
// four-entry byte queue has room. The result side gives one write per cycle
// from its output register while pop is high and bytes wait; a byte needs one
// write at even tile x, up to two at odd x, where both pixels straddle two
// bytes, so that register sets the sustained rate. frame_width (APB address
// 0) must be written only while idle (not enforced by the block). Odd values
// lose bit 0, large ones clamp to MAX_FRAME_WIDTH. Addresses wrap, unclipped.
module tile_blit_4bpp_transparent_unit #(
  parameter int MAX_FRAME_WIDTH = 1024,
  parameter int MAX_TILE_SIDE   = 32,
  parameter int ADDR_BITS       = 19
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // config port
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  // input beats
  input  wire logic                 push,
  output logic                      full,
  input  wire logic                 cmd,
  input  wire logic [9:0]           tile_x,
  input  wire logic [9:0]           tile_y,
  input  wire logic [5:0]           tile_side,
  input  wire logic                 transparent,
  input  wire logic [7:0]           tile_byte,
  // result beats
  output logic                      empty,
  input  wire logic                 pop,
  output logic [ADDR_BITS-1:0]      write_addr,
  output logic [7:0]                write_data,
  output logic [1:0]                nibble_mask,
  output logic                      last_of_run
);
  import tblit_pkg::*;

  localparam int QDEPTH = 4;
  localparam int QW     = ADDR_BITS + $bits(pix_op_t);

  logic [CFG_W-1:0]     frame_width;
  logic                 accept;
  logic                 op_push;
  logic [ADDR_BITS-1:0] f_addr;
  pix_op_t              f_op;
  logic [QW-1:0]        q_rd;
  logic                 q_empty;
  logic                 q_pop;
  logic [ADDR_BITS-1:0] b_addr;
  pix_op_t              b_op;

  // APB register: one word, no wait states
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FRAME_WIDTH) ? 32'(frame_width) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= FRAME_WIDTH_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_FRAME_WIDTH)) begin
      frame_width <= pwdata[CFG_W-1:0];
    end
  end

  // the queue filling up is the only thing that holds the input side
  assign accept = push && !full;

  tblit_front #(
    .MAX_FRAME_WIDTH (MAX_FRAME_WIDTH),
    .MAX_TILE_SIDE   (MAX_TILE_SIDE),
    .ADDR_BITS       (ADDR_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .frame_width (frame_width),
    .accept      (accept),
    .cmd         (cmd),
    .tile_x      (tile_x),
    .tile_y      (tile_y),
    .tile_side   (tile_side),
    .transparent (transparent),
    .tile_byte   (tile_byte),
    .op_push     (op_push),
    .op_addr     (f_addr),
    .op          (f_op)
  );

  // bytes with at least one pixel to write wait here for the back end
  tblit_fifo #(
    .WIDTH (QW),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (op_push),
    .wr_data ({f_addr, f_op}),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (q_rd),
    .empty   (q_empty)
  );

  assign b_addr = q_rd[QW-1 -: ADDR_BITS];
  assign b_op   = pix_op_t'(q_rd[$bits(pix_op_t)-1:0]);

  tblit_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .op_empty    (q_empty),
    .op_addr     (b_addr),
    .op          (b_op),
    .op_pop      (q_pop),
    .empty       (empty),
    .pop         (pop),
    .write_addr  (write_addr),
    .write_data  (write_data),
    .nibble_mask (nibble_mask),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire
